// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/sadf_pkg.sv =====
package sadf_pkg;

   // register indexes on the csr port
   localparam logic [2:0] REG_RADIUS_ZERO    = 3'd0;
   localparam logic [2:0] REG_INV_TAN_PITCH  = 3'd1;
   localparam logic [2:0] REG_PHASE_ZERO     = 3'd2;
   localparam logic [2:0] REG_ARM_COUNT      = 3'd3;
   localparam logic [2:0] REG_PERTURB_WEIGHT = 3'd4;
   localparam logic [2:0] REG_NORM_CONST     = 3'd5;
   localparam logic [2:0] REG_RATIO_INDEX    = 3'd6;

   localparam int LOG_FRAC_BITS = 16;
   localparam logic [31:0] LN2_OVER_2PI_Q32 = 32'd473811343;
   localparam logic [31:0] PI_Q30 = 32'd3373259426;
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
   localparam logic [18:0] RESULT_MAX = 19'h7FFFF;
   localparam logic [16:0] WEIGHT_ONE = 17'h10000;

   // Taylor divisors of the sine polynomial and floor(2^32/c)
   localparam int POLY_TERMS = 5;
   localparam logic [6:0] POLY_DIV [POLY_TERMS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
   localparam logic [31:0] POLY_RECIP [POLY_TERMS] =
      '{32'd39045157, 32'd59652323, 32'd102261126, 32'd214748364, 32'd715827882};

   typedef struct packed {
      logic [31:0] r_mant;
      logic [4:0]  r_k;
      logic [31:0] z_mant;
      logic [4:0]  z_k;
      logic [15:0] azimuth;
   } item_type;

   typedef struct packed {
      logic [23:0] inv_tan_pitch;
      logic [15:0] phase_zero;
      logic [4:0]  arms;
      logic [16:0] weight;
      logic [18:0] norm_const;
      logic [4:0]  power;
   } cfg_type;

   // floor(2^30 / m), quarter turn shared among the arms
   function automatic logic [31:0] arm_offset(input logic [4:0] m);
      logic [31:0] r;
      unique case (m)
         5'd2:  r = 32'd536870912;
         5'd3:  r = 32'd357913941;
         5'd4:  r = 32'd268435456;
         5'd5:  r = 32'd214748364;
         5'd6:  r = 32'd178956970;
         5'd7:  r = 32'd153391689;
         5'd8:  r = 32'd134217728;
         5'd9:  r = 32'd119304647;
         5'd10: r = 32'd107374182;
         5'd11: r = 32'd97612893;
         5'd12: r = 32'd89478485;
         5'd13: r = 32'd82595524;
         5'd14: r = 32'd76695844;
         5'd15: r = 32'd71582788;
         5'd16: r = 32'd67108864;
         5'd17: r = 32'd63161283;
         5'd18: r = 32'd59652323;
         5'd19: r = 32'd56512727;
         5'd20: r = 32'd53687091;
         5'd21: r = 32'd51130563;
         5'd22: r = 32'd48806446;
         5'd23: r = 32'd46684427;
         5'd24: r = 32'd44739242;
         5'd25: r = 32'd42949672;
         5'd26: r = 32'd41297762;
         5'd27: r = 32'd39768215;
         5'd28: r = 32'd38347922;
         5'd29: r = 32'd37025580;
         5'd30: r = 32'd35791394;
         5'd31: r = 32'd34636833;
         default: r = 32'd1073741824;
      endcase
      return r;
   endfunction

endpackage

// ===== sv/sadf_front.sv =====
module sadf_front
   import sadf_pkg::*;
(
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_radius,
   input  logic [15:0] req_azimuth,
   input  logic [31:0] radius_zero,
   input  logic        q_full,
   output logic        q_push,
   output item_type    q_item
);

   // normalize to Q1.31 mantissa and top-bit index; zero counts as one LSB
   function automatic logic [36:0] normalize(input logic [31:0] v);
      logic [31:0] vv;
      logic [4:0]  k;
      vv = (v == 32'd0) ? 32'd1 : v;
      k = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (vv[i]) k = 5'(i);
      end
      return {vv << (5'd31 - k), k};
   endfunction

   always_comb begin
      {q_item.r_mant, q_item.r_k} = normalize(req_radius);
      {q_item.z_mant, q_item.z_k} = normalize(radius_zero);
      q_item.azimuth = req_azimuth;
   end

   assign req_ready = !q_full;
   assign q_push = req_valid && !q_full;

endmodule

// ===== sv/sadf_queue.sv =====
module sadf_queue
   import sadf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type wr_data,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output item_type rd_data
);

   item_type   ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push_ok, pop_ok;

   assign full = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign push_ok = push && !full;
   assign pop_ok = pop && !empty;
   assign rd_data = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push_ok} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) ent_ff[wr_ptr_ff] <= wr_data;
   end

`include "assert_macros.svh"
   `ASSERT_CLK(a_count_up, clock, reset, (push_ok && !pop_ok) |=> count_ff == $past(count_ff) + 2'd1, "queue count did not advance on push")
   `ASSERT_CLK(a_head_hold, clock, reset, (!empty && !pop_ok) |=> rd_data == $past(rd_data), "queue head changed without pop")

endmodule

// ===== sv/sadf_log2.sv =====
module sadf_log2
   import sadf_pkg::*;
(
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] mant_in,
   output logic [15:0] frac_out
);

   // one fraction bit per stage by repeated squaring of the mantissa
   logic [31:0] mant_ff [LOG_FRAC_BITS];
   logic [15:0] frac_ff [LOG_FRAC_BITS];

   for (genvar i = 0; i < LOG_FRAC_BITS; i++) begin : g_step
      logic [31:0] m_prev;
      logic [15:0] f_prev;
      logic [63:0] sq;
      logic [32:0] t;
      if (i == 0) begin : g_first
         assign m_prev = mant_in;
         assign f_prev = 16'd0;
      end else begin : g_next
         assign m_prev = mant_ff[i-1];
         assign f_prev = frac_ff[i-1];
      end
      assign sq = 64'(m_prev) * 64'(m_prev);
      assign t = sq[63:31];
      always_ff @(posedge clock) begin
         if (en) begin
            mant_ff[i] <= t[32] ? t[32:1] : t[31:0];
            frac_ff[i] <= {f_prev[14:0], t[32]};
         end
      end
   end

   assign frac_out = frac_ff[LOG_FRAC_BITS-1];

endmodule

// ===== sv/sadf_back.sv =====
module sadf_back
   import sadf_pkg::*;
#(
   parameter int ANGLE_BITS = 16,
   parameter int MAX_INDEX = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        q_empty,
   input  item_type    q_item,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [18:0] rsp_density_factor
);

   localparam int DEPTH = LOG_FRAC_BITS + 7 + 3 * POLY_TERMS + 2 + MAX_INDEX + 3;

   typedef struct packed {
      logic [4:0]  r_k;
      logic [4:0]  z_k;
      logic [15:0] azimuth;
   } side_type;

   logic             en;
   logic [DEPTH-1:0] vld_ff;
   side_type         side_ff [LOG_FRAC_BITS];
   logic [15:0]      frac_r, frac_z;

   // advance everything together unless the output holds an untaken result
   assign en = !vld_ff[DEPTH-1] || rsp_ready;
   assign q_pop = en && !q_empty;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[DEPTH-2:0], q_pop};
   end

   sadf_log2 u_log_r (.clock(clock), .en(en), .mant_in(q_item.r_mant), .frac_out(frac_r));
   sadf_log2 u_log_z (.clock(clock), .en(en), .mant_in(q_item.z_mant), .frac_out(frac_z));

   for (genvar i = 0; i < LOG_FRAC_BITS; i++) begin : g_side
      if (i == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (en) side_ff[i] <= '{r_k: q_item.r_k, z_k: q_item.z_k,
                                    azimuth: q_item.azimuth};
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (en) side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // d = log2 R - log2 R0, magnitude and sign
   logic [5:0]  kd;
   logic [22:0] d;
   logic [21:0] mag_ff, mag_in;
   logic        neg_ff [3];
   logic [15:0] az_ff [3];
   logic [45:0] a_ff, a_in;
   logic [31:0] hi_ff, hi_in, lo_ff, lo_in;
   logic [63:0] lo_prod;
   logic [31:0] wind, theta_ff, theta_in;
   logic [31:0] x;
   logic [ANGLE_BITS-1:0] y, y_ff, y_in;
   logic [ANGLE_BITS+31:0] zp;
   logic [31:0] z_ff, z_in, z7_ff, z2_ff;
   logic [63:0] zsq;

   always_comb begin
      kd = {1'b0, side_ff[LOG_FRAC_BITS-1].r_k} - {1'b0, side_ff[LOG_FRAC_BITS-1].z_k};
      d = {kd[5], kd, 16'd0} + {7'd0, frac_r} - {7'd0, frac_z};
      mag_in = d[22] ? 22'(23'd0 - d) : d[21:0];
      a_in = 46'(mag_ff) * 46'(cfg.inv_tan_pitch);
      hi_in = 32'(46'(a_ff[45:32]) * 46'(LN2_OVER_2PI_Q32));
      lo_prod = 64'(a_ff[31:0]) * 64'(LN2_OVER_2PI_Q32);
      lo_in = lo_prod[63:32];
      wind = hi_ff + lo_ff;
      if (neg_ff[2]) wind = 32'd0 - wind;
      theta_in = wind + {cfg.phase_zero, 16'd0} + arm_offset(cfg.arms) - {az_ff[2], 16'd0};
      x = 32'(64'(theta_ff) * 64'(cfg.arms));
      y = x[31 -: ANGLE_BITS];
      // fold onto the first half turn
      y_in = (y > (ANGLE_BITS)'(1) << (ANGLE_BITS - 1)) ? (ANGLE_BITS)'(0) - y : y;
      zp = (ANGLE_BITS + 32)'(y_ff) * (ANGLE_BITS + 32)'(PI_Q30);
      z_in = zp[ANGLE_BITS+31:ANGLE_BITS];
      zsq = 64'(z_ff) * 64'(z_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= mag_in;
         neg_ff[0] <= d[22];
         neg_ff[1] <= neg_ff[0];
         neg_ff[2] <= neg_ff[1];
         az_ff[0] <= side_ff[LOG_FRAC_BITS-1].azimuth;
         az_ff[1] <= az_ff[0];
         az_ff[2] <= az_ff[1];
         a_ff <= a_in;
         hi_ff <= hi_in;
         lo_ff <= lo_in;
         theta_ff <= theta_in;
         y_ff <= y_in;
         z_ff <= z_in;
         z7_ff <= z_ff;
         z2_ff <= zsq[61:30];
      end
   end

   // sine polynomial, Horner form, three stages per term
   logic [30:0] p_ff [POLY_TERMS];
   logic [31:0] pz_ff [POLY_TERMS];
   logic [31:0] pz2_ff [POLY_TERMS];

   for (genvar i = 0; i < POLY_TERMS; i++) begin : g_poly
      logic [30:0] p_prev;
      logic [31:0] z_prev, z2_prev;
      logic [62:0] prod;
      logic [63:0] qprod;
      logic [38:0] qc;
      logic [31:0] r, q;
      logic [31:0] a_v_ff, a_z_ff, a_z2_ff;
      logic [31:0] b_v_ff, b_q_ff, b_z_ff, b_z2_ff;
      if (i == 0) begin : g_first
         assign p_prev = ONE_Q30;
         assign z_prev = z7_ff;
         assign z2_prev = z2_ff;
      end else begin : g_next
         assign p_prev = p_ff[i-1];
         assign z_prev = pz_ff[i-1];
         assign z2_prev = pz2_ff[i-1];
      end
      assign prod = 63'(z2_prev) * 63'(p_prev);
      assign qprod = 64'(a_v_ff) * 64'(POLY_RECIP[i]);
      assign qc = 39'(b_q_ff) * 39'(POLY_DIV[i]);
      assign r = b_v_ff - qc[31:0];
      // reciprocal estimate is at most one low
      assign q = (r >= 32'(POLY_DIV[i])) ? b_q_ff + 32'd1 : b_q_ff;
      always_ff @(posedge clock) begin
         if (en) begin
            a_v_ff <= prod[61:30];
            a_z_ff <= z_prev;
            a_z2_ff <= z2_prev;
            b_v_ff <= a_v_ff;
            b_q_ff <= qprod[63:32];
            b_z_ff <= a_z_ff;
            b_z2_ff <= a_z2_ff;
            p_ff[i] <= 31'(32'(ONE_Q30) - q);
            pz_ff[i] <= b_z_ff;
            pz2_ff[i] <= b_z2_ff;
         end
      end
   end

   logic [61:0] sn_prod, s_prod;
   logic [30:0] sn_ff, s_ff;

   always_comb begin
      sn_prod = 62'(pz_ff[POLY_TERMS-1]) * 62'(p_ff[POLY_TERMS-1]);
      s_prod = 62'(sn_ff) * 62'(sn_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sn_ff <= (sn_prod[61:30] > 32'(ONE_Q30)) ? ONE_Q30 : sn_prod[60:30];
         s_ff <= s_prod[60:30];
      end
   end

   // power of sin^2, one conditional multiply per stage
   logic [30:0] q_ff [MAX_INDEX];
   logic [30:0] qs_ff [MAX_INDEX];

   for (genvar i = 0; i < MAX_INDEX; i++) begin : g_pow
      logic [30:0] q_prev, s_prev;
      logic [61:0] mul;
      if (i == 0) begin : g_first
         assign q_prev = ONE_Q30;
         assign s_prev = s_ff;
      end else begin : g_next
         assign q_prev = q_ff[i-1];
         assign s_prev = qs_ff[i-1];
      end
      assign mul = 62'(q_prev) * 62'(s_prev);
      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[i] <= (5'(i) < cfg.power) ? mul[60:30] : q_prev;
            qs_ff[i] <= s_prev;
         end
      end
   end

   // scale by w*CN in two partial products, then offset and saturate
   logic [35:0] wc_ff;
   logic [28:0] q2_ff;
   logic [46:0] ph_ff, pl_ff;
   logic [64:0] sum;
   logic [21:0] res;
   logic [18:0] out_ff;

   always_comb begin
      sum = {ph_ff, 18'd0} + 65'(pl_ff);
      res = 22'(18'(18'h10000 - 18'(cfg.weight))) + 22'(sum[64:44]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wc_ff <= 36'(cfg.weight) * 36'(cfg.norm_const);
         q2_ff <= q_ff[MAX_INDEX-1][30:2];
         ph_ff <= 47'(wc_ff[35:18]) * 47'(q2_ff);
         pl_ff <= 47'(wc_ff[17:0]) * 47'(q2_ff);
         out_ff <= (res > 22'(RESULT_MAX)) ? RESULT_MAX : res[18:0];
      end
   end

   assign rsp_valid = vld_ff[DEPTH-1];
   assign rsp_density_factor = out_ff;

`include "assert_macros.svh"
   `ASSERT_CLK(a_stall_hold, clock, reset, !en |=> vld_ff == $past(vld_ff), "pipeline moved during stall")

endmodule

// ===== sv/spiral_arm_density_factor.sv =====
// channel   direction  handshake               payload
// req       in         req_valid / req_ready   req_radius, req_azimuth
// rsp       out        rsp_valid / rsp_ready   rsp_density_factor
// csr       in         csr_wr_en (no wait)     csr_index, csr_wdata
//
// One transfer per cycle is taken while rsp_ready stays high.
// From req transfer to rsp_valid an item passes a queue entry, 16 log2 squaring stages,
// 15 sine polynomial stages, one stage per sine power step,
// plus 12 winding, angle, sine and scaling stages.
// A stalled rsp holds the whole back pipeline; the two-entry queue then fills and
// drops req_ready. Reset empties the queue, clears the pipeline valids and sets the registers to their defaults.
module spiral_arm_density_factor
   import sadf_pkg::*;
#(
   parameter int ANGLE_BITS = 16,
   parameter int MAX_INDEX = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_radius,
   input  logic [15:0] req_azimuth,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [18:0] rsp_density_factor,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [31:0] radius_zero_ff;
   logic [23:0] inv_tan_pitch_ff;
   logic [15:0] phase_zero_ff;
   logic [4:0]  arm_count_ff;
   logic [16:0] perturb_weight_ff;
   logic [18:0] norm_const_ff;
   logic [3:0]  ratio_index_ff;

   // register file: plain writes, truncate to each register's width
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_zero_ff <= 32'd65536;
         inv_tan_pitch_ff <= 24'd65536;
         phase_zero_ff <= 16'd0;
         arm_count_ff <= 5'd2;
         perturb_weight_ff <= 17'd32768;
         norm_const_ff <= 19'd65536;
         ratio_index_ff <= 4'd0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_RADIUS_ZERO:    radius_zero_ff <= csr_wdata;
            REG_INV_TAN_PITCH:  inv_tan_pitch_ff <= csr_wdata[23:0];
            REG_PHASE_ZERO:     phase_zero_ff <= csr_wdata[15:0];
            REG_ARM_COUNT:      arm_count_ff <= csr_wdata[4:0];
            REG_PERTURB_WEIGHT: perturb_weight_ff <= csr_wdata[16:0];
            REG_NORM_CONST:     norm_const_ff <= csr_wdata[18:0];
            REG_RATIO_INDEX:    ratio_index_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // clamp: no arms counts as one, weight to one, index to its limit
   cfg_type cfg;
   always_comb begin
      cfg.inv_tan_pitch = inv_tan_pitch_ff;
      cfg.phase_zero = phase_zero_ff;
      cfg.arms = (arm_count_ff == 5'd0) ? 5'd1 : arm_count_ff;
      cfg.weight = (perturb_weight_ff > WEIGHT_ONE) ? WEIGHT_ONE : perturb_weight_ff;
      cfg.norm_const = norm_const_ff;
      cfg.power = ({1'b0, ratio_index_ff} > 5'(MAX_INDEX)) ? 5'(MAX_INDEX)
                                                         : {1'b0, ratio_index_ff};
   end

   item_type push_item, head_item;
   logic     q_full, q_push, q_empty, q_pop;

   sadf_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_radius  (req_radius),
      .req_azimuth (req_azimuth),
      .radius_zero (radius_zero_ff),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_item      (push_item)
   );

   sadf_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (push_item),
      .full    (q_full),
      .pop     (q_pop),
      .empty   (q_empty),
      .rd_data (head_item)
   );

   sadf_back #(
      .ANGLE_BITS (ANGLE_BITS),
      .MAX_INDEX  (MAX_INDEX)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .q_empty            (q_empty),
      .q_item             (head_item),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_density_factor (rsp_density_factor)
   );

endmodule

// ===== tb/tb_spiral_arm_density_factor.sv =====
`timescale 1ns / 1ps

module tb_spiral_arm_density_factor;
   import sadf_pkg::*;

   localparam int ANGLE_W = 16;
   localparam int IDX_MAX = 10;
   localparam int PIPE_DEPTH = 43 + IDX_MAX;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 950;
   // an index past the register list
   localparam logic [2:0] REG_NONE = 3'd7;

   typedef struct packed {
      logic [31:0] radius;
      logic [15:0] azimuth;
   } point_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_radius;
   logic [15:0] req_azimuth;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [18:0] rsp_density_factor;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   spiral_arm_density_factor dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_radius(req_radius), .req_azimuth(req_azimuth),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_density_factor(rsp_density_factor),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow copy of the block's registers
   logic [31:0] sh_r0;
   logic [23:0] sh_itp;
   logic [15:0] sh_phi0;
   logic [4:0]  sh_arms;
   logic [16:0] sh_weight;
   logic [18:0] sh_cn;
   logic [3:0]  sh_ratio;

   point_type   point_q[$];
   logic [18:0] density_q[$];
   int          mismatches;
   int          accepted_pts;
   int          checked_pts;
   int          idle_cycles;
   bit          drain_hold;
   bit          stim_done;
   int          burst_left;
   int          gap_left;
   int          stall_phase;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // log2 of a Q16.16 value as signed Q.16, by repeated squaring
   function automatic logic signed [31:0] log2_fix(input logic [31:0] v);
      int          k;
      logic [63:0] mant;
      logic [15:0] frac;
      k = 31;
      frac = '0;
      if (v == 0) v = 32'd1;
      while (k > 0 && v[k] == 1'b0) k--;
      mant = {32'd0, v << (31 - k)};
      for (int i = 0; i < 16; i++) begin
         mant = (mant * mant) >> 31;
         frac = frac << 1;
         if (mant >= 64'h1_0000_0000) begin
            frac[0] = 1'b1;
            mant = mant >> 1;
         end
      end
      return (k - 16) * 65536 + frac;
   endfunction

   // sin^2(pi*y), y folded into a half turn; result Q.30
   function automatic logic [63:0] sine_squared(input logic [63:0] y);
      logic [63:0] z, z2, p, sn;
      int          divs [5];
      divs = '{110, 72, 42, 20, 6};
      z = (y * 64'd3373259426) >> ANGLE_W;
      z2 = (z * z) >> 30;
      p = 64'd1 << 30;
      for (int i = 0; i < 5; i++)
         p = (64'd1 << 30) - (((z2 * p) >> 30) / divs[i]);
      sn = (z * p) >> 30;
      if (sn > (64'd1 << 30)) sn = 64'd1 << 30;
      return (sn * sn) >> 30;
   endfunction

   function automatic logic [18:0] density_of(input point_type pt);
      logic [31:0]        m, wind, theta, x;
      logic [63:0]        w, mag, a, turns, y, s, q, term, res;
      int                 n;
      logic signed [31:0] d;
      m = (sh_arms == 0) ? 32'd1 : {27'd0, sh_arms};
      w = (sh_weight > 17'd65536) ? 64'd65536 : {47'd0, sh_weight};
      n = (sh_ratio > IDX_MAX) ? IDX_MAX : sh_ratio;
      d = log2_fix(pt.radius) - log2_fix(sh_r0);
      mag = (d < 0) ? 64'(-64'(d)) : 64'(d);
      a = mag * sh_itp;
      turns = (a >> 32) * 64'd473811343 + (((a & 64'hFFFF_FFFF) * 64'd473811343) >> 32);
      wind = turns[31:0];
      if (d < 0) wind = 32'd0 - wind;
      theta = wind + {sh_phi0, 16'd0} + (32'd1 << 30) / m - {pt.azimuth, 16'd0};
      x = m * theta;
      y = 64'(x >> (32 - ANGLE_W));
      if (y > (64'd1 << (ANGLE_W - 1))) y = (64'd1 << ANGLE_W) - y;
      s = sine_squared(y);
      q = 64'd1 << 30;
      for (int i = 0; i < n; i++) q = (q * s) >> 30;
      // keep the scaled product wide before the shift
      term = 64'(((128'(w * sh_cn)) * 128'(q >> 2)) >> 44);
      res = (64'd65536 - w) + term;
      if (res > 64'd524287) res = 64'd524287;
      return res[18:0];
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_RADIUS_ZERO:    sh_r0 = val;
         REG_INV_TAN_PITCH:  sh_itp = val[23:0];
         REG_PHASE_ZERO:     sh_phi0 = val[15:0];
         REG_ARM_COUNT:      sh_arms = val[4:0];
         REG_PERTURB_WEIGHT: sh_weight = val[16:0];
         REG_NORM_CONST:     sh_cn = val[18:0];
         REG_RATIO_INDEX:    sh_ratio = val[3:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // hold until the pipeline has emptied, then settle
   task automatic wait_idle();
      while (point_q.size() != 0 || req_valid || density_q.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_radius();
      case ($urandom_range(0, 5))
         0: return $urandom_range(1, 255);
         1: return 32'hFFFF_FFFF - $urandom_range(0, 255);
         2: return 32'h0001_0000 + $urandom_range(0, 4095) - 2048;
         default: return $urandom() | 32'd1;
      endcase
   endfunction

   task automatic add_points(input int count);
      point_type pt;
      for (int i = 0; i < count; i++) begin
         pt.radius = pick_radius();
         pt.azimuth = 16'($urandom());
         point_q.push_back(pt);
      end
   endtask

   task automatic add_point(input logic [31:0] r, input logic [15:0] az);
      point_type pt;
      pt.radius = r;
      pt.azimuth = az;
      point_q.push_back(pt);
   endtask

   // driver: send in bursts with random gaps; hold payload until transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (!(req_valid && !req_ready)) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (point_q.size() != 0 && !drain_hold) begin
            req_valid <= 1'b1;
            req_radius <= point_q[0].radius;
            req_azimuth <= point_q[0].azimuth;
            void'(point_q.pop_front());
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // predict on every input transfer
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         density_q.push_back(density_of({req_radius, req_azimuth}));
         accepted_pts++;
      end
   end

   // receiver stall pattern: long ready stretches, short and long stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_phase <= 0;
      end else begin
         stall_phase <= stall_phase + 1;
         if (stall_phase[8:7] == 2'd0) rsp_ready <= 1'b1;
         else if (stall_phase[8:7] == 2'd1) rsp_ready <= ($urandom_range(0, 3) != 0);
         else rsp_ready <= ($urandom_range(0, 9) == 0) ? ~rsp_ready : rsp_ready;
      end
   end

   // monitor: compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (density_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected density_factor %0d", rsp_density_factor);
         end else begin
            if (rsp_density_factor !== density_q[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: density_factor expected %0d got %0d",
                           density_q[0], rsp_density_factor);
            end
            void'(density_q.pop_front());
            checked_pts++;
         end
      end
   end

   // watchdog: count cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (stim_done && density_q.size() == 0)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", density_q.size());
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      req_valid = 1'b0;
      req_radius = '0;
      req_azimuth = '0;
      rsp_ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      mismatches = 0;
      accepted_pts = 0;
      checked_pts = 0;
      idle_cycles = 0;
      drain_hold = 1'b0;
      stim_done = 1'b0;
      burst_left = 0;
      gap_left = 0;
      stall_phase = 0;
      sh_r0 = 32'd65536;
      sh_itp = 24'd65536;
      sh_phi0 = 16'd0;
      sh_arms = 5'd2;
      sh_weight = 17'd32768;
      sh_cn = 19'd65536;
      sh_ratio = 4'd0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, field extremes, zero radius
      add_point(32'd0, 16'd0);
      add_point(32'd1, 16'hFFFF);
      add_point(32'hFFFF_FFFF, 16'h8000);
      add_point(32'h0001_0000, 16'h4000);
      add_point(32'h0000_8000, 16'h0001);
      add_point(32'h0002_0000, 16'h7FFF);
      wait_idle();

      // zero radius, pitch and arm count; oversized weight and index
      write_reg(REG_RADIUS_ZERO, 32'd0);
      write_reg(REG_INV_TAN_PITCH, 32'd0);
      write_reg(REG_ARM_COUNT, 32'd0);
      write_reg(REG_PERTURB_WEIGHT, 32'h1FFFF);
      write_reg(REG_NORM_CONST, 32'h7FFFF);
      write_reg(REG_RATIO_INDEX, 32'd15);
      write_reg(REG_NONE, 32'hDEAD_BEEF);
      add_point(32'd0, 16'd0);
      add_point(32'd5, 16'h2000);
      add_point(32'hFFFF_FFFF, 16'hC000);
      add_point(32'h1234_5678, 16'hFFFF);
      wait_idle();

      // top extremes: peak saturation, tight winding
      write_reg(REG_RADIUS_ZERO, 32'hFFFF_FFFF);
      write_reg(REG_INV_TAN_PITCH, 32'hFF_FFFF);
      write_reg(REG_PHASE_ZERO, 32'hFFFF);
      write_reg(REG_ARM_COUNT, 32'd31);
      write_reg(REG_PERTURB_WEIGHT, 32'd65536);
      write_reg(REG_RATIO_INDEX, 32'd1);
      add_point(32'd1, 16'd0);
      add_point(32'hFFFF_FFFF, 16'hFFFF);
      add_point(32'h0000_0100, 16'h1234);
      add_point(32'h8000_0000, 16'h8000);
      wait_idle();

      // random phases, each with its own register settings
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(REG_RADIUS_ZERO, (ph == 0) ? 32'd1 : ($urandom() | 32'd1));
         write_reg(REG_INV_TAN_PITCH, (ph == 1) ? 32'd1 : $urandom_range(1, 24'hFF_FFFF));
         write_reg(REG_PHASE_ZERO, $urandom());
         write_reg(REG_ARM_COUNT, (ph == 2) ? 32'd1 : (ph == 3) ? 32'd16 : $urandom_range(0, 31));
         write_reg(REG_PERTURB_WEIGHT, (ph == 4) ? 32'd1 : $urandom_range(1, 17'h1FFFF));
         write_reg(REG_NORM_CONST, (ph == 5) ? 32'd65536 : (ph == 6) ? 32'd393216
                   : $urandom_range(0, 19'h7FFFF));
         write_reg(REG_RATIO_INDEX, (ph == 7) ? 32'd10 : $urandom_range(0, 15));
         add_points(RANDOM_ITEMS / 8);
         if (ph == 4) begin
            // pause the sender until every pending result has drained
            while (point_q.size() > RANDOM_ITEMS / 16) @(posedge clock);
            drain_hold = 1'b1;
            while (req_valid || density_q.size() != 0) @(posedge clock);
            drain_hold = 1'b0;
         end
         wait_idle();
      end

      stim_done = 1'b1;
      repeat (PIPE_DEPTH + 10) @(posedge clock);
      $display("run covered %0d points, %0d results checked, 11 register settings",
               accepted_pts, checked_pts);
      $display("including zero and saturating registers and random stall patterns");
      if (mismatches == 0 && density_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("mismatches %0d, outstanding %0d", mismatches, density_q.size());
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
